/* rtl/mv4_pkg.sv */
// mv4_pkg: shared constants, opcode codes and pipeline control type
// for the 4x4 matrix-vector transform; no dependencies
package mv4_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VEC_N         = 4;
    localparam int ELEM_W        = 32;
    localparam int MAT_N         = VEC_N * VEC_N;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 2 * ELEM_W;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int VEC_DATA_W    = VEC_N * ELEM_W;

    typedef enum logic
    {
        OP_MAT_VEC = 1'b0,
        OP_VEC_MAT = 1'b1
    } op_t;

    // stage load enables handed from the top level to every lane
    typedef struct packed
    {
        logic prod_en;
        logic sum_en;
        logic sat_en;
    } pipe_ctrl_t;

endpackage

/* rtl/mv4_lane.sv */
// mv4_lane: one output element, four products, exact sum, floor shift, saturate
// depends on mv4_pkg
module mv4_lane #(
    parameter int FRAC_BITS = mv4_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  mv4_pkg::pipe_ctrl_t                     ctrl,
    input  logic signed [mv4_pkg::ELEM_W-1:0]       coef [mv4_pkg::VEC_N],
    input  logic signed [mv4_pkg::ELEM_W-1:0]       vec  [mv4_pkg::VEC_N],
    output logic signed [mv4_pkg::ELEM_W-1:0]       result,
    output logic                                    sat
);

    logic signed [mv4_pkg::PROD_W-1:0] prod_reg [mv4_pkg::VEC_N];
    logic signed [mv4_pkg::SUM_W-1:0]  sum_reg;
    logic signed [mv4_pkg::SUM_W-1:0]  sum_next;
    logic signed [mv4_pkg::SUM_W-1:0]  shifted;
    logic [mv4_pkg::SUM_W-mv4_pkg::ELEM_W:0] high_bits;
    logic                              fits;
    logic signed [mv4_pkg::ELEM_W-1:0] result_reg;
    logic signed [mv4_pkg::ELEM_W-1:0] result_next;
    logic                              sat_reg;
    logic                              sat_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            for (int k = 0; k < mv4_pkg::VEC_N; k++)
            begin
                prod_reg[k] <= coef[k] * vec[k];
            end
        end
    end

    assign sum_next = mv4_pkg::SUM_W'(prod_reg[0]) + mv4_pkg::SUM_W'(prod_reg[1])
                    + mv4_pkg::SUM_W'(prod_reg[2]) + mv4_pkg::SUM_W'(prod_reg[3]);

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    // arithmetic shift of the exact sum rounds toward minus infinity
    always_comb
    begin
        shifted   = sum_reg >>> FRAC_BITS;
        high_bits = shifted[mv4_pkg::SUM_W-1:mv4_pkg::ELEM_W-1];
        fits      = (&high_bits) || (~|high_bits);
        sat_next  = !fits;
        if (fits)
        begin
            result_next = shifted[mv4_pkg::ELEM_W-1:0];
        end
        else if (sum_reg[mv4_pkg::SUM_W-1])
        begin
            result_next = {1'b1, {(mv4_pkg::ELEM_W-1){1'b0}}};
        end
        else
        begin
            result_next = {1'b0, {(mv4_pkg::ELEM_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sat_en)
        begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

/* rtl/mv4_merge.sv */
// mv4_merge: output register that packs the four lane results and merges
// their saturation flags; depends on mv4_pkg
module mv4_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [mv4_pkg::ELEM_W-1:0]   lane_result [mv4_pkg::VEC_N],
    input  logic [mv4_pkg::VEC_N-1:0]           lane_sat,
    output logic                                load_en,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mv4_pkg::VEC_DATA_W-1:0]      m_tdata,
    output logic [0:0]                          m_tuser
);

    logic                               valid_reg;
    logic                               valid_next;
    logic [mv4_pkg::VEC_DATA_W-1:0]     data_reg;
    logic [mv4_pkg::VEC_DATA_W-1:0]     data_next;
    logic                               sat_reg;

    assign load_en    = !valid_reg || m_tready;
    assign valid_next = load_en ? in_valid : valid_reg;

    always_comb
    begin
        for (int i = 0; i < mv4_pkg::VEC_N; i++)
        begin
            data_next[i*mv4_pkg::ELEM_W +: mv4_pkg::ELEM_W] = lane_result[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            data_reg <= data_next;
            sat_reg  <= |lane_sat;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = sat_reg;

endmodule

/* rtl/mat4_vector_transform.sv */
// mat4_vector_transform: 4x4 Q16.16 matrix times vector, or vector times matrix
// by opcode, four lanes in parallel; an item passes the product, sum and
// saturate registers, then the output register; one item per cycle sustained
// while m_tready holds; every stage loads while empty or while the stage after
// it moves on; reset clears all valid bits and loads the identity matrix
// depends on mv4_pkg, mv4_lane, mv4_merge
module mat4_vector_transform #(
    parameter int FRAC_BITS = mv4_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mv4_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mv4_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mv4_pkg::VEC_DATA_W-1:0]      s_tdata,  // vx, vy, vz, vw
    input  logic [0:0]                          s_tuser,  // opcode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mv4_pkg::VEC_DATA_W-1:0]      m_tdata,  // rx, ry, rz, rw
    output logic [0:0]                          m_tuser   // saturated
);

    localparam logic [mv4_pkg::ELEM_W-1:0] ONE = mv4_pkg::ELEM_W'(1) << FRAC_BITS;

    logic [mv4_pkg::ELEM_W-1:0]         mat_reg [mv4_pkg::MAT_N];
    logic                               prod_valid_reg;
    logic                               prod_valid_next;
    logic                               sum_valid_reg;
    logic                               sum_valid_next;
    logic                               sat_valid_reg;
    logic                               sat_valid_next;
    logic                               out_en;
    mv4_pkg::pipe_ctrl_t                ctrl;
    logic signed [mv4_pkg::ELEM_W-1:0]  vec [mv4_pkg::VEC_N];
    logic signed [mv4_pkg::ELEM_W-1:0]  coef [mv4_pkg::VEC_N][mv4_pkg::VEC_N];
    logic signed [mv4_pkg::ELEM_W-1:0]  lane_result [mv4_pkg::VEC_N];
    logic [mv4_pkg::VEC_N-1:0]          lane_sat;

    // column-major storage: element e is row e%4, column e/4
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < mv4_pkg::MAT_N; e++)
            begin
                mat_reg[e] <= (e / mv4_pkg::VEC_N == e % mv4_pkg::VEC_N) ? ONE : '0;
            end
        end
        else
        begin
            for (int p = 0; p < mv4_pkg::MAT_N / 2; p++)
            begin
                if (cfg_we && cfg_index == mv4_pkg::CFG_IDX_W'(p))
                begin
                    mat_reg[2*p]   <= cfg_data[mv4_pkg::ELEM_W-1:0];
                    mat_reg[2*p+1] <= cfg_data[mv4_pkg::CFG_DATA_W-1:mv4_pkg::ELEM_W];
                end
            end
        end
    end

    // per-stage flow control
    always_comb
    begin
        ctrl.sat_en     = !sat_valid_reg || out_en;
        ctrl.sum_en     = !sum_valid_reg || ctrl.sat_en;
        ctrl.prod_en    = !prod_valid_reg || ctrl.sum_en;
        prod_valid_next = ctrl.prod_en ? s_tvalid : prod_valid_reg;
        sum_valid_next  = ctrl.sum_en ? prod_valid_reg : sum_valid_reg;
        sat_valid_next  = ctrl.sat_en ? sum_valid_reg : sat_valid_reg;
    end

    assign s_tready = ctrl.prod_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            sat_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            sum_valid_reg  <= sum_valid_next;
            sat_valid_reg  <= sat_valid_next;
        end
    end

    // lane i uses row i, or column i when the matrix is transposed
    always_comb
    begin
        for (int k = 0; k < mv4_pkg::VEC_N; k++)
        begin
            vec[k] = s_tdata[k*mv4_pkg::ELEM_W +: mv4_pkg::ELEM_W];
        end
        for (int i = 0; i < mv4_pkg::VEC_N; i++)
        begin
            for (int k = 0; k < mv4_pkg::VEC_N; k++)
            begin
                if (mv4_pkg::op_t'(s_tuser[0]) == mv4_pkg::OP_VEC_MAT)
                begin
                    coef[i][k] = mat_reg[i*mv4_pkg::VEC_N + k];
                end
                else
                begin
                    coef[i][k] = mat_reg[k*mv4_pkg::VEC_N + i];
                end
            end
        end
    end

    for (genvar g = 0; g < mv4_pkg::VEC_N; g++)
    begin : g_lane
        mv4_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .ctrl   (ctrl),
            .coef   (coef[g]),
            .vec    (vec),
            .result (lane_result[g]),
            .sat    (lane_sat[g])
        );
    end

    mv4_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (sat_valid_reg),
        .lane_result (lane_result),
        .lane_sat    (lane_sat),
        .load_en     (out_en),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

/* rtl/mv4_checker.sv */
// mv4_checker: port-level checks for mat4_vector_transform, bound to the top level
// depends on mv4_pkg and mat4_vector_transform
module mv4_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [mv4_pkg::VEC_DATA_W-1:0]      m_tdata,
    input  logic [0:0]                          m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // with the output side free the pipeline never refuses an item
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

    // an accepted item reaches the output when nothing stalls
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("item did not arrive after pipeline latency");

endmodule

bind mat4_vector_transform mv4_checker u_mv4_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
